FILE: src/overcurrent_frequency_throttle_macros.svh
// Assertion macros shared by the throttle RTL.
// Requires a clock named clk and an active-low reset named rst_n in the including module.
`ifndef OVERCURRENT_FREQUENCY_THROTTLE_MACROS_SVH
`define OVERCURRENT_FREQUENCY_THROTTLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OFT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ofth_pkg.sv
// Package for the over-current frequency throttle: command and register codes,
// field widths, reset values and arithmetic constants. No dependencies.
package ofth_pkg;

    localparam int NUM_LEVELS_DEF = 16;

    localparam int CFG_W  = 24;
    localparam int FREQ_W = 24;
    localparam int CNT_W  = 32;
    localparam int LVL_W  = 4;

    // Commands carried by one input beat.
    typedef enum logic [2:0] {
        CMD_EVENT   = 3'd0,
        CMD_TICK    = 3'd1,
        CMD_ENABLE  = 3'd2,
        CMD_DISABLE = 3'd3,
        CMD_LOAD    = 3'd4
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_DOWN_STEP    = 3'd0,
        REG_LEVEL_COUNT  = 3'd1,
        REG_RELEASE_MODE = 3'd2,
        REG_THRESHOLD    = 3'd3,
        REG_DURATION     = 3'd4,
        REG_TOP_LEVEL    = 3'd5,
        REG_NO_OCP_LEVEL = 3'd6
    } cfg_reg_t;

    // Release modes; codes above REL_ALWAYS also release unconditionally.
    typedef enum logic [1:0] {
        REL_CURRENT = 2'd0,
        REL_UTIL    = 2'd1,
        REL_ALWAYS  = 2'd2
    } rel_mode_t;

    localparam logic [15:0] CUR_COEFF = 16'd46875;
    localparam logic [6:0]  PERCENT   = 7'd100;

    localparam logic [3:0]  DOWN_STEP_RST   = 4'd1;
    localparam logic [4:0]  LEVEL_COUNT_RST = 5'd16;
    localparam logic [15:0] DURATION_RST    = 16'd100;

endpackage

FILE: src/overcurrent_frequency_throttle.sv
// Over-current frequency throttle, top level.
// Depends on ofth_pkg and on overcurrent_frequency_throttle_macros.svh.
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ----------------------------------------------
//  input     in_valid / in_stall     command, entry_index, entry_freq, adc_current,
//                                    util_sum, capacity_total
//  result    out_valid / out_stall   clipped_level, limit_freq, throttled, active,
//                                    limit_changed, transitions, level_ticks
//  config    cfg_we                  cfg_index, cfg_data (write only, no wait)
//
// One beat in and one beat out per cycle unless out_stall holds; a taken beat is held in the
// input register, its result in the result register. The state update is a single pass from
// the input register to the state and result registers: one item per clock when unstalled.
// Reset restores the registers and state and clears the tick counters; the frequency
// table is not cleared and holds garbage until loaded.
// A stalled result holds; the input register then fills and in_stall rises.
module overcurrent_frequency_throttle #(
    parameter int NUM_LEVELS = ofth_pkg::NUM_LEVELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [ofth_pkg::CFG_W-1:0]  cfg_data,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  command,
    input  logic [3:0]                  entry_index,
    input  logic [ofth_pkg::FREQ_W-1:0] entry_freq,
    input  logic [7:0]                  adc_current,
    input  logic [15:0]                 util_sum,
    input  logic [15:0]                 capacity_total,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ofth_pkg::LVL_W-1:0]  clipped_level,
    output logic [ofth_pkg::FREQ_W-1:0] limit_freq,
    output logic                        throttled,
    output logic                        active,
    output logic                        limit_changed,
    output logic [ofth_pkg::CNT_W-1:0]  transitions,
    output logic [ofth_pkg::CNT_W-1:0]  level_ticks
);
    import ofth_pkg::*;

    `include "overcurrent_frequency_throttle_macros.svh"

    // Entry indexes are four bits wide, so no more than sixteen entries are reachable.
    localparam int         STORE_DEPTH = (NUM_LEVELS < 16) ? NUM_LEVELS : 16;
    localparam int         IDX_W       = $clog2(STORE_DEPTH);
    localparam logic [4:0] DEPTH_W5    = 5'(STORE_DEPTH);

    // Configuration registers.
    logic [3:0]  down_step_reg;
    logic [4:0]  level_count_reg;
    logic [1:0]  release_mode_reg;
    logic [23:0] threshold_reg;
    logic [15:0] duration_reg;
    logic [3:0]  top_level_reg;
    logic [3:0]  no_ocp_level_reg;

    // Input register.
    logic              item_valid_reg;
    logic [2:0]        item_cmd_reg;
    logic [3:0]        item_idx_reg;
    logic [FREQ_W-1:0] item_freq_reg;
    logic [7:0]        item_adc_reg;
    logic [15:0]       item_util_reg;
    logic [15:0]       item_cap_reg;

    // Throttle state; the result beat is a view of it.
    logic [LVL_W-1:0]  level_reg,        level_next;
    logic              held_reg,         held_next;
    logic              protect_reg,      protect_next;
    logic              armed_reg,        armed_next;
    logic [15:0]       release_cnt_reg,  release_cnt_next;
    logic [CNT_W-1:0]  change_count_reg, change_count_next;
    logic [CNT_W-1:0]  ticks_reg [STORE_DEPTH];
    logic [FREQ_W-1:0] freq_mem  [STORE_DEPTH];

    // Result register.
    logic              out_valid_reg,    out_valid_next;
    logic              changed_reg,      changed_next;
    logic [3:0]        shown_idx_reg;
    logic              shown_ok_reg,     shown_ok_next;
    logic [FREQ_W-1:0] freq_out_reg;

    logic              advance;
    logic              in_accept;
    logic              tick_inc;
    logic              freq_we;
    logic              release_ok;
    logic              item_idx_ok;
    logic [3:0]        last_level;
    logic [4:0]        eff_count;
    logic [4:0]        stepped;
    logic [23:0]       cur_prod;
    logic [22:0]       util_pct;
    logic [39:0]       cap_thr;

    // An item moves into the state whenever the result register is free or being taken.
    assign advance   = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = item_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    function automatic logic [3:0] clamp_level(input logic [4:0] v, input logic [3:0] last);
        clamp_level = (v > {1'b0, last}) ? last : v[3:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_step_reg    <= DOWN_STEP_RST;
            level_count_reg  <= LEVEL_COUNT_RST;
            release_mode_reg <= REL_CURRENT;
            threshold_reg    <= '0;
            duration_reg     <= DURATION_RST;
            top_level_reg    <= '0;
            no_ocp_level_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DOWN_STEP:    down_step_reg    <= cfg_data[3:0];
                REG_LEVEL_COUNT:  level_count_reg  <= cfg_data[4:0];
                REG_RELEASE_MODE: release_mode_reg <= cfg_data[1:0];
                REG_THRESHOLD:    threshold_reg    <= cfg_data[23:0];
                REG_DURATION:     duration_reg     <= cfg_data[15:0];
                REG_TOP_LEVEL:    top_level_reg    <= cfg_data[3:0];
                REG_NO_OCP_LEVEL: no_ocp_level_reg <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= in_accept || (item_valid_reg && !advance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_cmd_reg  <= command;
            item_idx_reg  <= entry_index;
            item_freq_reg <= entry_freq;
            item_adc_reg  <= adc_current;
            item_util_reg <= util_sum;
            item_cap_reg  <= capacity_total;
        end
    end

    // Last level in use: min(level_count, table depth) - 1, with a count of zero as one.
    always_comb
    begin
        eff_count  = (level_count_reg == 5'd0) ? 5'd1 : level_count_reg;
        eff_count  = (eff_count > DEPTH_W5) ? DEPTH_W5 : eff_count;
        last_level = 4'(eff_count - 5'd1);
    end

    assign item_idx_ok = {1'b0, item_idx_reg} < DEPTH_W5;

    // Release check: one multiplier for current mode, two for utilisation mode.
    assign cur_prod = {16'b0, item_adc_reg} * {8'b0, CUR_COEFF};
    assign util_pct = {7'b0, item_util_reg} * {16'b0, PERCENT};
    assign cap_thr  = {24'b0, item_cap_reg} * {16'b0, threshold_reg};

    always_comb
    begin
        case (release_mode_reg)
            REL_CURRENT: release_ok = cur_prod < threshold_reg;
            REL_UTIL:    release_ok = {17'b0, util_pct} < cap_thr;
            default:     release_ok = 1'b1;
        endcase
    end

    assign stepped = {1'b0, level_reg} + {1'b0, down_step_reg};

    always_comb
    begin
        level_next        = level_reg;
        held_next         = held_reg;
        protect_next      = protect_reg;
        armed_next        = armed_reg;
        release_cnt_next  = release_cnt_reg;
        change_count_next = change_count_reg;
        changed_next      = 1'b0;
        tick_inc          = 1'b0;
        freq_we           = 1'b0;
        if (advance)
        begin
            case (item_cmd_reg)
                CMD_EVENT:
                begin
                    if (protect_reg)
                    begin
                        held_next = 1'b1;
                        if (down_step_reg != 4'd0)
                        begin
                            level_next = clamp_level(stepped, last_level);
                        end
                        else
                        begin
                            level_next = clamp_level({1'b0, top_level_reg}, last_level);
                        end
                        change_count_next = change_count_reg + 1'b1;
                        changed_next      = 1'b1;
                        armed_next        = 1'b1;
                        release_cnt_next  = duration_reg;
                    end
                end
                CMD_TICK:
                begin
                    if (protect_reg)
                    begin
                        tick_inc = 1'b1;
                        if (armed_reg)
                        begin
                            // A count of zero or one means the window ends on this tick.
                            if (release_cnt_reg <= 16'd1)
                            begin
                                if (release_ok)
                                begin
                                    held_next         = 1'b0;
                                    armed_next        = 1'b0;
                                    release_cnt_next  = '0;
                                    level_next        = clamp_level({1'b0, top_level_reg},
                                                                    last_level);
                                    change_count_next = change_count_reg + 1'b1;
                                    changed_next      = 1'b1;
                                end
                                else
                                begin
                                    release_cnt_next = duration_reg;
                                end
                            end
                            else
                            begin
                                release_cnt_next = release_cnt_reg - 16'd1;
                            end
                        end
                    end
                end
                CMD_ENABLE:
                begin
                    if (!protect_reg)
                    begin
                        level_next   = clamp_level({1'b0, top_level_reg}, last_level);
                        protect_next = 1'b1;
                        changed_next = 1'b1;
                    end
                end
                CMD_DISABLE:
                begin
                    if (protect_reg)
                    begin
                        armed_next       = 1'b0;
                        release_cnt_next = '0;
                        held_next        = 1'b0;
                        level_next       = clamp_level({1'b0, no_ocp_level_reg}, last_level);
                        protect_next     = 1'b0;
                        changed_next     = 1'b1;
                    end
                end
                CMD_LOAD:
                begin
                    freq_we = item_idx_ok;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = advance || (out_valid_reg && out_stall);
        shown_ok_next  = item_idx_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg        <= '0;
            held_reg         <= 1'b0;
            protect_reg      <= 1'b1;
            armed_reg        <= 1'b0;
            release_cnt_reg  <= '0;
            change_count_reg <= '0;
            out_valid_reg    <= 1'b0;
            changed_reg      <= 1'b0;
            shown_ok_reg     <= 1'b0;
            shown_idx_reg    <= '0;
        end
        else
        begin
            level_reg        <= level_next;
            held_reg         <= held_next;
            protect_reg      <= protect_next;
            armed_reg        <= armed_next;
            release_cnt_reg  <= release_cnt_next;
            change_count_reg <= change_count_next;
            out_valid_reg    <= out_valid_next;
            if (advance)
            begin
                changed_reg   <= changed_next;
                shown_ok_reg  <= shown_ok_next;
                shown_idx_reg <= item_idx_reg;
            end
        end
    end

    // Each counter has its own incrementer and counts ticks taken at its level while protected.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                ticks_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                if (tick_inc && (level_reg == LVL_W'(i)))
                begin
                    ticks_reg[i] <= ticks_reg[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (freq_we)
        begin
            freq_mem[item_idx_reg[IDX_W-1:0]] <= item_freq_reg;
        end
        if (advance)
        begin
            // A load into the entry that the limit lands on is passed straight through.
            if (freq_we && (item_idx_reg[IDX_W-1:0] == level_next[IDX_W-1:0]))
            begin
                freq_out_reg <= item_freq_reg;
            end
            else
            begin
                freq_out_reg <= freq_mem[level_next[IDX_W-1:0]];
            end
        end
    end

    // State changes only together with the result register, so the outputs read it directly.
    assign out_valid     = out_valid_reg;
    assign clipped_level = level_reg;
    assign limit_freq    = freq_out_reg;
    assign throttled     = held_reg;
    assign active        = protect_reg;
    assign limit_changed = changed_reg;
    assign transitions   = change_count_reg;
    assign level_ticks   = shown_ok_reg ? ticks_reg[shown_idx_reg[IDX_W-1:0]] : '0;

    `OFT_ASSERT_NOW(a_level_in_table, 1'b1, {1'b0, level_reg} < DEPTH_W5,
                    "limit level beyond the frequency table")
    `OFT_ASSERT_NOW(a_held_means_armed, 1'b1, held_reg == armed_reg,
                    "throttled flag and release timer disagree")
    `OFT_ASSERT_NOW(a_disabled_idle, !protect_reg, !held_reg && !armed_reg,
                    "limit held while protection is disabled")
    `OFT_ASSERT_NEXT(a_count_needs_item, !advance, $stable(change_count_reg),
                     "transition count moved without an item")
    `OFT_ASSERT_NEXT(a_item_gives_result, advance, out_valid_reg,
                     "processed item produced no result beat")

endmodule

FILE: test/tb.sv
// Self-checking testbench for overcurrent_frequency_throttle: directed table, then random phases.
// Needs ofth_pkg and the throttle RTL; the expected status of untyped beats comes from an
// in-bench copy of the throttle state machine, typed beats carry their own expected status.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ofth_pkg::*;

    localparam int LEVELS       = NUM_LEVELS_DEF;
    localparam int RANDOM_BEATS = 1600;
    localparam int LONG_HOLD    = 80;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam logic [1:0] REL_SPARE     = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  entry_index;
        logic [23:0] entry_freq;
        logic [7:0]  adc_current;
        logic [15:0] util_sum;
        logic [15:0] capacity_total;
    } throttle_req_t;

    typedef struct packed {
        logic [3:0]  clipped_level;
        logic [23:0] limit_freq;
        logic        throttled;
        logic        active;
        logic        limit_changed;
        logic [31:0] transitions;
        logic [31:0] level_ticks;
    } throttle_status_t;

    typedef struct packed {
        bit               is_write;
        cfg_reg_t         reg_sel;
        logic [23:0]      reg_val;
        throttle_req_t    req;
        bit               typed;
        throttle_status_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    throttle_req_t req_bus;
    logic out_valid;
    logic out_stall;
    logic [LVL_W-1:0] clipped_level;
    logic [FREQ_W-1:0] limit_freq;
    logic throttled;
    logic active;
    logic limit_changed;
    logic [CNT_W-1:0] transitions;
    logic [CNT_W-1:0] level_ticks;

    // Register copies used by the predictor.
    logic [3:0]  cfg_down_step;
    logic [4:0]  cfg_level_count;
    logic [1:0]  cfg_release_mode;
    logic [23:0] cfg_threshold;
    logic [15:0] cfg_duration;
    logic [3:0]  cfg_top_level;
    logic [3:0]  cfg_no_ocp_level;

    // Throttle state as the predictor sees it.
    logic [3:0]  limit_lvl;
    logic        held_now;
    logic        prot_on;
    logic        countdown_armed;
    logic [15:0] countdown;
    logic [31:0] change_total;
    logic [31:0] ticks_per_level[LEVELS];
    logic [23:0] level_freq[LEVELS];

    throttle_status_t status_due[$];
    plan_row_t        plan_q[$];

    int  mismatches;
    int  beats_taken;
    int  results_checked;
    int  reg_writes;
    int  limit_moves;
    bit  idle_on;
    bit  long_hold_req;

    always #6 clk = ~clk;

    overcurrent_frequency_throttle #(.NUM_LEVELS(LEVELS)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (req_bus.command),
        .entry_index    (req_bus.entry_index),
        .entry_freq     (req_bus.entry_freq),
        .adc_current    (req_bus.adc_current),
        .util_sum       (req_bus.util_sum),
        .capacity_total (req_bus.capacity_total),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .clipped_level  (clipped_level),
        .limit_freq     (limit_freq),
        .throttled      (throttled),
        .active         (active),
        .limit_changed  (limit_changed),
        .transitions    (transitions),
        .level_ticks    (level_ticks)
    );

    // A zero level count behaves as one, and nothing goes past the table.
    function automatic logic [3:0] clamp_level(input logic [4:0] want_lvl);
        int unsigned n;
        n = cfg_level_count;
        if (n == 0) n = 1;
        if (n > LEVELS) n = LEVELS;
        if (n > 16) n = 16;
        return (want_lvl > n - 1) ? 4'(n - 1) : want_lvl[3:0];
    endfunction

    function automatic bit release_allowed(input throttle_req_t rq);
        case (cfg_release_mode)
            REL_CURRENT: return 64'(rq.adc_current) * 64'(CUR_COEFF) < 64'(cfg_threshold);
            REL_UTIL:    return 64'(rq.util_sum) * 64'(PERCENT)
                                < 64'(rq.capacity_total) * 64'(cfg_threshold);
            default:     return 1'b1;
        endcase
    endfunction

    function automatic throttle_status_t advance_throttle(input throttle_req_t rq);
        throttle_status_t st;
        logic moved;
        moved = 1'b0;
        case (rq.command)
            CMD_EVENT:
                if (prot_on)
                begin
                    held_now = 1'b1;
                    if (cfg_down_step != 0)
                        limit_lvl = clamp_level(5'(limit_lvl) + 5'(cfg_down_step));
                    else
                        limit_lvl = clamp_level(5'(cfg_top_level));
                    change_total++;
                    moved = 1'b1;
                    countdown_armed = 1'b1;
                    countdown = cfg_duration;
                end
            CMD_TICK:
                if (prot_on)
                begin
                    ticks_per_level[limit_lvl]++;
                    if (countdown_armed)
                    begin
                        if (countdown <= 1)
                        begin
                            if (release_allowed(rq))
                            begin
                                held_now = 1'b0;
                                countdown_armed = 1'b0;
                                countdown = '0;
                                limit_lvl = clamp_level(5'(cfg_top_level));
                                change_total++;
                                moved = 1'b1;
                            end
                            else
                            begin
                                countdown = cfg_duration;
                            end
                        end
                        else
                        begin
                            countdown--;
                        end
                    end
                end
            CMD_ENABLE:
                if (!prot_on)
                begin
                    limit_lvl = clamp_level(5'(cfg_top_level));
                    prot_on = 1'b1;
                    moved = 1'b1;
                end
            CMD_DISABLE:
                if (prot_on)
                begin
                    countdown_armed = 1'b0;
                    countdown = '0;
                    held_now = 1'b0;
                    limit_lvl = clamp_level(5'(cfg_no_ocp_level));
                    prot_on = 1'b0;
                    moved = 1'b1;
                end
            CMD_LOAD:
                if (rq.entry_index < LEVELS) level_freq[rq.entry_index] = rq.entry_freq;
            default: ;
        endcase
        if (moved) limit_moves++;
        st.clipped_level = limit_lvl;
        st.limit_freq    = level_freq[limit_lvl];
        st.throttled     = held_now;
        st.active        = prot_on;
        st.limit_changed = moved;
        st.transitions   = change_total;
        st.level_ticks   = (rq.entry_index < LEVELS) ? ticks_per_level[rq.entry_index] : '0;
        return st;
    endfunction

    function automatic void add_write(input cfg_reg_t which, input logic [23:0] value);
        plan_row_t row;
        row = '0;
        row.is_write = 1'b1;
        row.reg_sel = which;
        row.reg_val = value;
        plan_q.push_back(row);
    endfunction

    function automatic void add_beat(input logic [2:0] cmd, input logic [3:0] idx,
                                     input logic [7:0] adc, input logic [15:0] util,
                                     input logic [15:0] cap, input bit typed,
                                     input throttle_status_t want);
        plan_row_t row;
        row = '0;
        row.req.command = cmd;
        row.req.entry_index = idx;
        row.req.adc_current = adc;
        row.req.util_sum = util;
        row.req.capacity_total = cap;
        row.typed = typed;
        row.want = want;
        plan_q.push_back(row);
    endfunction

    function automatic throttle_req_t random_request();
        throttle_req_t rq;
        int unsigned pick;
        int unsigned knee;
        pick = $urandom_range(0, 99);
        if (pick < 50) rq.command = CMD_TICK;
        else if (pick < 66) rq.command = CMD_EVENT;
        else if (pick < 76) rq.command = CMD_LOAD;
        else if (pick < 84) rq.command = CMD_ENABLE;
        else if (pick < 88) rq.command = CMD_DISABLE;
        else if (pick < 92) rq.command = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        else rq.command = CMD_TICK;
        rq.entry_index = 4'($urandom_range(0, 15));
        rq.entry_freq = 24'($urandom_range(0, 24'hFFFFFF));
        // Readings close to the current threshold exercise both sides of the compare.
        knee = cfg_threshold / CUR_COEFF;
        case ($urandom_range(0, 7))
            0:       rq.adc_current = 8'd0;
            1:       rq.adc_current = 8'hFF;
            2, 3:    rq.adc_current = (knee > 255) ? 8'hFF : 8'(knee + $urandom_range(0, 1));
            default: rq.adc_current = 8'($urandom_range(0, 255));
        endcase
        rq.util_sum = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(0, 16'hFFFF));
        rq.capacity_total = ($urandom_range(0, 7) == 0) ? 16'd0
                                                        : 16'($urandom_range(0, 16'hFFFF));
        return rq;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic write_reg(input cfg_reg_t which, input logic [23:0] value);
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        case (which)
            REG_DOWN_STEP:    cfg_down_step = value[3:0];
            REG_LEVEL_COUNT:  cfg_level_count = value[4:0];
            REG_RELEASE_MODE: cfg_release_mode = value[1:0];
            REG_THRESHOLD:    cfg_threshold = value;
            REG_DURATION:     cfg_duration = value[15:0];
            REG_TOP_LEVEL:    cfg_top_level = value[3:0];
            REG_NO_OCP_LEVEL: cfg_no_ocp_level = value[3:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one beat and returns at the edge that takes it.
    task automatic drive_beat(input throttle_req_t rq, input bit typed,
                              input throttle_status_t want);
        logic [95:0] noise;
        throttle_status_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            noise = {$urandom, $urandom, $urandom};
            in_valid <= 1'b0;
            req_bus <= noise[$bits(throttle_req_t)-1:0];
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_bus <= rq;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = advance_throttle(rq);
        status_due.push_back(typed ? want : predicted);
        beats_taken++;
    endtask

    task automatic drain(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (status_due.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic pick_setting(input int unsigned phase);
        logic [1:0] mode;
        int unsigned k;
        if (phase == 0)
        begin
            write_reg(REG_DOWN_STEP, 24'd15);
            write_reg(REG_LEVEL_COUNT, 24'd31);
            write_reg(REG_RELEASE_MODE, 24'(REL_SPARE));
            write_reg(REG_THRESHOLD, 24'hFFFFFF);
            write_reg(REG_DURATION, 24'hFFFF);
            write_reg(REG_TOP_LEVEL, 24'd15);
            write_reg(REG_NO_OCP_LEVEL, 24'd15);
        end
        else if (phase == 1)
        begin
            write_reg(REG_DOWN_STEP, 24'd1);
            write_reg(REG_LEVEL_COUNT, 24'd1);
            write_reg(REG_RELEASE_MODE, 24'(REL_CURRENT));
            write_reg(REG_THRESHOLD, 24'd0);
            write_reg(REG_DURATION, 24'd1);
            write_reg(REG_TOP_LEVEL, 24'd0);
            write_reg(REG_NO_OCP_LEVEL, 24'd0);
        end
        else
        begin
            mode = 2'($urandom_range(0, 3));
            k = $urandom_range(0, 255);
            write_reg(REG_DOWN_STEP, ($urandom_range(0, 4) == 0)
                      ? 24'($urandom_range(0, 1) * 15) : 24'($urandom_range(1, 4)));
            case ($urandom_range(0, 5))
                0:       write_reg(REG_LEVEL_COUNT, 24'($urandom_range(0, 1)));
                1:       write_reg(REG_LEVEL_COUNT, 24'($urandom_range(16, 31)));
                default: write_reg(REG_LEVEL_COUNT, 24'($urandom_range(2, 16)));
            endcase
            write_reg(REG_RELEASE_MODE, 24'(mode));
            if (mode == REL_UTIL)
                write_reg(REG_THRESHOLD, ($urandom_range(0, 5) == 0)
                          ? 24'hFFFFFF : 24'($urandom_range(0, 120)));
            else if ($urandom_range(0, 1))
                write_reg(REG_THRESHOLD, 24'(k * CUR_COEFF + $urandom_range(0, 1)));
            else
                write_reg(REG_THRESHOLD, 24'($urandom_range(0, 24'hFFFFFF)));
            case ($urandom_range(0, 7))
                0:       write_reg(REG_DURATION, 24'hFFFF);
                1:       write_reg(REG_DURATION, 24'($urandom_range(1, 300)));
                default: write_reg(REG_DURATION, 24'($urandom_range(0, 6)));
            endcase
            write_reg(REG_TOP_LEVEL, 24'($urandom_range(0, 15)));
            write_reg(REG_NO_OCP_LEVEL, 24'($urandom_range(0, 15)));
        end
    endtask

    // Result side: checks every beat taken and drives the stall pattern.
    initial
    begin : result_monitor
        throttle_status_t got;
        throttle_status_t want;
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = '{clipped_level, limit_freq, throttled, active, limit_changed,
                        transitions, level_ticks};
                if (status_due.size() == 0)
                begin
                    $error("result beat arrived with nothing pending");
                    mismatches++;
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("clipped_level", 32'(want.clipped_level), 32'(got.clipped_level));
                    check_field("limit_freq", 32'(want.limit_freq), 32'(got.limit_freq));
                    check_field("throttled", 32'(want.throttled), 32'(got.throttled));
                    check_field("active", 32'(want.active), 32'(got.active));
                    check_field("limit_changed", 32'(want.limit_changed),
                                32'(got.limit_changed));
                    check_field("transitions", want.transitions, got.transitions);
                    check_field("level_ticks", want.level_ticks, got.level_ticks);
                    results_checked++;
                end
            end
            if (long_hold_req)
            begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        throttle_req_t rq;
        int unsigned phase;
        int unsigned span;
        int unsigned random_beats;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_DOWN_STEP;
        cfg_data <= '0;
        in_valid <= 1'b0;
        req_bus <= '0;
        mismatches = 0;
        beats_taken = 0;
        results_checked = 0;
        reg_writes = 0;
        limit_moves = 0;
        idle_on = 1'b1;
        long_hold_req = 1'b0;

        cfg_down_step = DOWN_STEP_RST;
        cfg_level_count = LEVEL_COUNT_RST;
        cfg_release_mode = REL_CURRENT;
        cfg_threshold = '0;
        cfg_duration = DURATION_RST;
        cfg_top_level = '0;
        cfg_no_ocp_level = '0;
        limit_lvl = '0;
        held_now = 1'b0;
        prot_on = 1'b1;
        countdown_armed = 1'b0;
        countdown = '0;
        change_total = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            ticks_per_level[i] = '0;
            level_freq[i] = '0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The frequency table powers up unknown, so every entry is loaded before the
        // limit can move. Entry n holds n * 0x111111, which spans 0 to full scale.
        for (int i = 0; i < LEVELS; i++)
        begin
            rq = '0;
            rq.command = CMD_LOAD;
            rq.entry_index = 4'(i);
            rq.entry_freq = 24'(i * 24'h111111);
            rq.adc_current = 8'($urandom_range(0, 255));
            drive_beat(rq, 1'b0, '0);
        end

        // Reset defaults: one level per event, sixteen levels, current-meter release.
        add_beat(CMD_TICK, 4'd0, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1,
                 '{4'd0, 24'h000000, 1'b0, 1'b1, 1'b0, 32'd0, 32'd1});
        add_beat(CMD_EVENT, 4'd1, 8'd0, 16'd0, 16'd0, 1'b1,
                 '{4'd1, 24'h111111, 1'b1, 1'b1, 1'b1, 32'd1, 32'd0});
        add_write(REG_DOWN_STEP, 24'd15);
        add_beat(CMD_EVENT, 4'd15, 8'd0, 16'd0, 16'd0, 1'b1,
                 '{4'd15, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, 32'd2, 32'd0});
        // Already at the slowest level: no move, but it still counts as a change.
        add_beat(CMD_EVENT, 4'd0, 8'd0, 16'd0, 16'd0, 1'b1,
                 '{4'd15, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, 32'd3, 32'd1});
        add_write(REG_DURATION, 24'd0);
        add_write(REG_TOP_LEVEL, 24'd3);
        add_write(REG_DOWN_STEP, 24'd0);
        add_write(REG_THRESHOLD, 24'(255 * CUR_COEFF));
        // Zero step jumps to the top level; zero duration expires on the next tick.
        add_beat(CMD_EVENT, 4'd3, 8'd0, 16'd0, 16'd0, 1'b1,
                 '{4'd3, 24'h333333, 1'b1, 1'b1, 1'b1, 32'd4, 32'd0});
        add_beat(CMD_TICK, 4'd3, 8'd255, 16'd0, 16'd0, 1'b1,
                 '{4'd3, 24'h333333, 1'b1, 1'b1, 1'b0, 32'd4, 32'd1});
        add_beat(CMD_TICK, 4'd3, 8'd254, 16'd0, 16'd0, 1'b1,
                 '{4'd3, 24'h333333, 1'b0, 1'b1, 1'b1, 32'd5, 32'd2});
        add_write(REG_RELEASE_MODE, 24'(REL_UTIL));
        add_write(REG_THRESHOLD, 24'd50);
        add_write(REG_DOWN_STEP, 24'd2);
        add_write(REG_DURATION, 24'd2);
        add_beat(CMD_EVENT, 4'd5, 8'd0, 16'd0, 16'd0, 1'b0, '0);
        add_beat(CMD_TICK, 4'd5, 8'd0, 16'd0, 16'd0, 1'b0, '0);
        add_beat(CMD_TICK, 4'd5, 8'd0, 16'd50, 16'd100, 1'b0, '0);
        add_beat(CMD_TICK, 4'd5, 8'd0, 16'hFFFF, 16'hFFFF, 1'b0, '0);
        add_beat(CMD_TICK, 4'd5, 8'd0, 16'd49, 16'd100, 1'b0, '0);
        add_write(REG_RELEASE_MODE, 24'(REL_SPARE));
        add_beat(CMD_EVENT, 4'd7, 8'hFF, 16'd0, 16'd0, 1'b0, '0);
        add_beat(CMD_TICK, 4'd7, 8'hFF, 16'hFFFF, 16'd0, 1'b0, '0);
        add_beat(CMD_TICK, 4'd3, 8'hFF, 16'hFFFF, 16'd0, 1'b0, '0);
        // Level count 4: every level written is clamped to 3.
        add_write(REG_LEVEL_COUNT, 24'd4);
        add_write(REG_NO_OCP_LEVEL, 24'd15);
        add_beat(CMD_DISABLE, 4'd3, 8'd0, 16'd0, 16'd0, 1'b0, '0);
        add_beat(CMD_DISABLE, 4'd3, 8'd0, 16'd0, 16'd0, 1'b0, '0);
        add_beat(CMD_EVENT, 4'd3, 8'd0, 16'd0, 16'd0, 1'b0, '0);
        add_beat(CMD_TICK, 4'd3, 8'd0, 16'd0, 16'd0, 1'b0, '0);
        add_write(REG_TOP_LEVEL, 24'd15);
        add_beat(CMD_ENABLE, 4'd3, 8'd0, 16'd0, 16'd0, 1'b0, '0);
        add_beat(CMD_ENABLE, 4'd3, 8'd0, 16'd0, 16'd0, 1'b0, '0);
        add_beat(CMD_UNUSED_LO, 4'd15, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, '0);
        add_beat(CMD_UNUSED_HI, 4'd0, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, '0);
        add_write(REG_LEVEL_COUNT, 24'd0);
        add_beat(CMD_EVENT, 4'd0, 8'd0, 16'd0, 16'd0, 1'b0, '0);

        foreach (plan_q[n])
        begin
            if (plan_q[n].is_write)
            begin
                drain(4);
                write_reg(plan_q[n].reg_sel, plan_q[n].reg_val);
            end
            else
            begin
                drive_beat(plan_q[n].req, plan_q[n].typed, plan_q[n].want);
            end
        end

        random_beats = 0;
        phase = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            drain(4);
            pick_setting(phase);
            if (RANDOM_BEATS - random_beats <= 200)
            begin
                // Closing stretch runs back to back on both sides.
                idle_on = 1'b0;
                span = RANDOM_BEATS - random_beats;
            end
            else
            begin
                idle_on = (phase != 1) && ($urandom_range(0, 3) != 0);
                span = $urandom_range(60, 140);
            end
            // Phase 1 holds the result side long enough for the input to back up.
            if (phase == 1) long_hold_req = 1'b1;
            for (int unsigned i = 0; i < span; i++)
            begin
                if (phase == 2 && i == span / 2) drain(0);
                drive_beat(random_request(), 1'b0, '0);
                random_beats++;
            end
            phase++;
        end

        drain(12);
        $display("Run covered %0d input beats and %0d register writes; %0d results checked.",
                 beats_taken, reg_writes, results_checked);
        $display("The predicted limit moved %0d times across %0d random phases.",
                 limit_moves, phase);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
